// ===== src/rbe_pkg.sv =====
// Shared constants, command and status records for the rANS byte encoder.
package rbe_pkg;

  // Field widths.
  localparam int CMD_W   = 2;
  localparam int SYM_W   = 8;
  localparam int COUNT_W = 13;
  localparam int KIND_W  = 2;
  localparam int STATE_W = 24;
  localparam int SUM_W   = 21;
  localparam int BYTE_W  = 8;

  // Alphabet and probability precision.
  localparam int SYMBOL_COUNT    = 256;
  localparam int PRECISION_BITS  = 12;
  localparam int SYM_IDX_W       = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int LOWER_BOUND_LOG = 16;

  // Renormalization bound is count << XMAX_SHIFT.
  localparam int XMAX_SHIFT = LOWER_BOUND_LOG - PRECISION_BITS + BYTE_W;
  localparam int CMP_W      = STATE_W + COUNT_W;
  localparam int MAX_BYTES  = 2;
  localparam int NBYTES_W   = $clog2(MAX_BYTES + 1);

  // Divider retires DIV_BITS quotient bits per cycle.
  localparam int DIV_BITS  = 2;
  localparam int DIV_ITERS = STATE_W / DIV_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_ITERS);

  localparam logic [STATE_W-1:0] LOWER_BOUND = STATE_W'(1) << LOWER_BOUND_LOG;
  localparam logic [SUM_W-1:0]   FULL_SUM    = SUM_W'(1) << PRECISION_BITS;

  // Request commands.
  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ENCODE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FINISH = 2'd2;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_BYTE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FINAL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic lookup;
    logic latch;
    logic emit_byte;
    logic push_error;
    logic div_init;
    logic div_step;
    logic update;
    logic push_final;
  } ctl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic slot_free;
    logic freq_zero;
    logic emit_ok;
    logic div_last;
  } dp_stat_t;

endpackage

// ===== src/rbe_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rbe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/rbe_dp.sv =====
// Datapath: symbol table, coder state, running sum, divider and result register.
module rbe_dp
  import rbe_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  ctl_cmd_t            cmd,
  output dp_stat_t            stat,
  input  logic [SYM_W-1:0]    in_symbol,
  input  logic [COUNT_W-1:0]  in_count,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [KIND_W-1:0]   out_kind,
  output logic [STATE_W-1:0]  out_data,
  output logic                out_table_bad,
  output logic                out_last
);

  logic [SYMBOL_COUNT-1:0] tab_vld_r;
  logic                    vld_rd_r;
  logic [STATE_W-1:0]      coder_r;
  logic [SUM_W-1:0]        sum_r;
  logic [COUNT_W-1:0]      freq_r;
  logic [COUNT_W-1:0]      start_r;
  logic [STATE_W-1:0]      acc_r;
  logic [COUNT_W-1:0]      rem_r;
  logic [NBYTES_W-1:0]     nbytes_r;
  logic [DIV_CNT_W-1:0]    div_cnt_r;

  logic                    out_valid_r;
  logic [KIND_W-1:0]       out_kind_r;
  logic [STATE_W-1:0]      out_data_r;
  logic                    out_bad_r;
  logic                    out_last_r;

  logic                    sym_ok;
  logic [SYM_IDX_W-1:0]    sym_idx;
  logic                    sym_zero;
  logic [SUM_W-1:0]        sum_base;
  logic [SUM_W-1:0]        sum_nxt;
  logic [2*COUNT_W-1:0]    ram_wdata;
  logic [2*COUNT_W-1:0]    ram_rdata;

  logic [CMP_W-1:0]        xmax;
  logic                    x_ge;
  logic                    more_bytes;
  logic [STATE_W-1:0]      acc_shift;

  logic [COUNT_W:0]        trial;
  logic [COUNT_W-1:0]      div_rem;
  logic [STATE_W-1:0]      div_quo;
  logic [STATE_W-1:0]      coder_upd;
  logic                    push;

  assign sym_ok   = (32'(in_symbol) < SYMBOL_COUNT);
  assign sym_idx  = in_symbol[SYM_IDX_W-1:0];
  assign sym_zero = (in_symbol == '0);

  // Symbol 0 restarts the cumulative sum.
  assign sum_base  = sym_zero ? '0 : sum_r;
  assign sum_nxt   = sum_base + SUM_W'(in_count);
  assign ram_wdata = {in_count, sum_base[COUNT_W-1:0]};

  rbe_ram #(
    .WIDTH (2 * COUNT_W),
    .DEPTH (SYMBOL_COUNT)
  ) u_tab (
    .clk   (clk),
    .we    (cmd.load && sym_ok),
    .waddr (sym_idx),
    .wdata (ram_wdata),
    .re    (cmd.lookup),
    .raddr (sym_idx),
    .rdata (ram_rdata)
  );

  // Renormalization test for this byte and for the one after it.
  assign acc_shift  = acc_r >> BYTE_W;
  assign xmax       = CMP_W'(freq_r) << XMAX_SHIFT;
  assign x_ge       = (CMP_W'(acc_r) >= xmax);
  assign more_bytes = (32'(nbytes_r) + 1 < MAX_BYTES) && (CMP_W'(acc_shift) >= xmax);

  // Restoring divide, DIV_BITS quotient bits per cycle.
  always_comb begin
    div_rem = rem_r;
    div_quo = acc_r;
    trial   = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      trial   = {div_rem, div_quo[STATE_W-1]};
      div_quo = {div_quo[STATE_W-2:0], 1'b0};
      if (trial >= {1'b0, freq_r}) begin
        trial      = trial - {1'b0, freq_r};
        div_quo[0] = 1'b1;
      end
      div_rem = trial[COUNT_W-1:0];
    end
  end

  assign coder_upd = (acc_r << PRECISION_BITS) + STATE_W'(rem_r) + STATE_W'(start_r);

  assign push = cmd.emit_byte || cmd.push_error || cmd.push_final;

  assign stat.slot_free = !out_valid_r || out_ready;
  assign stat.freq_zero = (freq_r == '0);
  assign stat.emit_ok   = (32'(nbytes_r) < MAX_BYTES) && x_ge;
  assign stat.div_last  = (div_cnt_r == DIV_CNT_W'(DIV_ITERS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tab_vld_r   <= '0;
      coder_r     <= LOWER_BOUND;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load && sym_ok) begin
        tab_vld_r[sym_idx] <= 1'b1;
        sum_r              <= sum_nxt;
      end
      if (cmd.update) begin
        coder_r <= coder_upd;
      end else if (cmd.push_final) begin
        coder_r <= LOWER_BOUND;
      end
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      vld_rd_r <= sym_ok && tab_vld_r[sym_idx];
    end
    if (cmd.latch) begin
      freq_r   <= vld_rd_r ? ram_rdata[2*COUNT_W-1:COUNT_W] : '0;
      start_r  <= vld_rd_r ? ram_rdata[COUNT_W-1:0] : '0;
      acc_r    <= coder_r;
      nbytes_r <= '0;
    end else if (cmd.emit_byte) begin
      acc_r    <= acc_shift;
      nbytes_r <= nbytes_r + 1'b1;
    end else if (cmd.div_step) begin
      acc_r <= div_quo;
    end
    if (cmd.div_init) begin
      rem_r     <= '0;
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r     <= div_rem;
      div_cnt_r <= div_cnt_r + 1'b1;
    end
    if (cmd.emit_byte) begin
      out_kind_r <= KIND_BYTE;
      out_data_r <= STATE_W'(acc_r[BYTE_W-1:0]);
      out_bad_r  <= 1'b0;
      out_last_r <= !more_bytes;
    end else if (cmd.push_error) begin
      out_kind_r <= KIND_ERROR;
      out_data_r <= '0;
      out_bad_r  <= 1'b0;
      out_last_r <= 1'b1;
    end else if (cmd.push_final) begin
      out_kind_r <= KIND_FINAL;
      out_data_r <= coder_r;
      out_bad_r  <= (sum_r != FULL_SUM);
      out_last_r <= 1'b1;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_data      = out_data_r;
  assign out_table_bad = out_bad_r;
  assign out_last      = out_last_r;

endmodule

// ===== src/rbe_ctrl.sv =====
// Controller: sequences load, encode and finish requests over the datapath.
module rbe_ctrl
  import rbe_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CMD_W-1:0] in_command,
  input  dp_stat_t         stat,
  output ctl_cmd_t         cmd
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_LOOK  = 6'b000010,
    ST_CHECK = 6'b000100,
    ST_DIV   = 6'b001000,
    ST_UPD   = 6'b010000,
    ST_FIN   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          priority if (in_command == CMD_LOAD) begin
            cmd.load = 1'b1;
          end else if (in_command == CMD_ENCODE) begin
            cmd.lookup = 1'b1;
            state_nxt  = ST_LOOK;
          end else if (in_command == CMD_FINISH) begin
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_LOOK: begin
        cmd.latch = 1'b1;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        // Hold while the result register is full and a result is to be pushed.
        priority if (stat.freq_zero) begin
          if (stat.slot_free) begin
            cmd.push_error = 1'b1;
            state_nxt      = ST_IDLE;
          end
        end else if (stat.emit_ok) begin
          if (stat.slot_free) begin
            cmd.emit_byte = 1'b1;
          end
        end else begin
          cmd.div_init = 1'b1;
          state_nxt    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_FIN: begin
        if (stat.slot_free) begin
          cmd.push_final = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== src/rans_byte_encoder.sv =====
// Top level of the byte-renormalizing rANS encoder.
//
//   channel  direction  ports
//   -------  ---------  ------------------------------------------------------
//   in       request    in_valid, in_ready, in_command, in_symbol, in_count
//   out      result     out_valid, out_ready, out_kind, out_data,
//                       out_table_bad, out_last
//
// A load request is written straight into the symbol table. A finish
// request goes through its own state to push the final result. An encode
// request reads the table, latches count and start, emits each spilled
// byte, runs the 24 by 13 bit divide at two quotient bits per cycle, and
// updates the state; a zero-count encode pushes an error instead. Reset
// clears the per-symbol valid bits at once, so there is no clearing pass.
// A full result register stalls the controller at the point where it would
// push a result; requests are taken only when the controller is idle, while
// the last result may still wait in the output register.
module rans_byte_encoder
  import rbe_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [CMD_W-1:0]    in_command,
  input  logic [SYM_W-1:0]    in_symbol,
  input  logic [COUNT_W-1:0]  in_count,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [KIND_W-1:0]   out_kind,
  output logic [STATE_W-1:0]  out_data,
  output logic                out_table_bad,
  output logic                out_last
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // Sequencing: request decode, byte emission loop, divide iterations.
  rbe_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Tables, coder state, running sum, divider and result register.
  rbe_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_symbol     (in_symbol),
    .in_count      (in_count),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_kind      (out_kind),
    .out_data      (out_data),
    .out_table_bad (out_table_bad),
    .out_last      (out_last)
  );

endmodule

// ===== sim/tb_rans_byte_encoder.sv =====
// Testbench for rans_byte_encoder: directed and random requests against a predictor.
`timescale 1ns / 1ps

module tb_rans_byte_encoder
  import rbe_pkg::*;
();

  // Command 3 has no package name; the block must drop it silently.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // Run bounds: hard stop on the cycle counter, settle time after the last result.
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int PRINT_LIMIT   = 40;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [STATE_W-1:0] data;
    logic               table_bad;
    logic               last;
  } enc_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [CMD_W-1:0]    in_command = '0;
  logic [SYM_W-1:0]    in_symbol = '0;
  logic [COUNT_W-1:0]  in_count = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [KIND_W-1:0]   out_kind;
  logic [STATE_W-1:0]  out_data;
  logic                out_table_bad;
  logic                out_last;

  // Idling knobs, set per test phase.
  int idle_pct  = 0;
  int stall_pct = 0;

  // The test bumps hold_requests; the receiver alone tracks hold_served.
  int hold_requests = 0;
  int hold_served   = 0;

  int          requests_sent = 0;
  int          fail_count    = 0;
  int unsigned cycle_count   = 0;

  // Encoder state as the predictor sees it.
  logic [COUNT_W-1:0] sym_count [SYMBOL_COUNT];
  logic [COUNT_W-1:0] sym_start [SYMBOL_COUNT];
  logic [STATE_W-1:0] coder_state;
  logic [SUM_W-1:0]   count_sum;

  // Results still owed by the block, oldest first.
  enc_result_t owed_results[$];

  rans_byte_encoder DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_command    (in_command),
    .in_symbol     (in_symbol),
    .in_count      (in_count),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_kind      (out_kind),
    .out_data      (out_data),
    .out_table_bad (out_table_bad),
    .out_last      (out_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void owe_result(input logic [KIND_W-1:0] kind,
                                     input logic [STATE_W-1:0] data,
                                     input logic bad, input logic last);
    enc_result_t r;
    r.kind      = kind;
    r.data      = data;
    r.table_bad = bad;
    r.last      = last;
    owed_results.push_back(r);
  endfunction

  function automatic void clear_encoder();
    for (int s = 0; s < SYMBOL_COUNT; s++) begin
      sym_count[s] = '0;
      sym_start[s] = '0;
    end
    coder_state = LOWER_BOUND;
    count_sum   = '0;
  endfunction

  // Advance the predicted state by one accepted request and queue what it owes.
  function automatic void encode_request(input logic [CMD_W-1:0] cmd,
                                         input logic [SYM_W-1:0] sym,
                                         input logic [COUNT_W-1:0] cnt);
    logic [63:0]       x;
    logic [63:0]       freq;
    logic [63:0]       renorm_bound;
    logic [BYTE_W-1:0] spilled [MAX_BYTES];
    int                n;
    n = 0;
    unique case (cmd)
      CMD_LOAD: begin
        // Symbol 0 opens a new table, so restart the cumulative sum.
        if (sym == 0) count_sum = '0;
        sym_count[sym] = cnt;
        sym_start[sym] = count_sum[COUNT_W-1:0];
        count_sum      = count_sum + SUM_W'(cnt);
      end
      CMD_ENCODE: begin
        freq = 64'(sym_count[sym]);
        if (freq == 0) begin
          owe_result(KIND_ERROR, '0, 1'b0, 1'b1);
        end else begin
          renorm_bound = freq << XMAX_SHIFT;
          x = 64'(coder_state);
          while (x >= renorm_bound && n < MAX_BYTES) begin
            spilled[n] = x[BYTE_W-1:0];
            x = x >> BYTE_W;
            n++;
          end
          x = ((x / freq) << PRECISION_BITS) + (x % freq) + 64'(sym_start[sym]);
          coder_state = x[STATE_W-1:0];
          for (int k = 0; k < n; k++)
            owe_result(KIND_BYTE, STATE_W'(spilled[k]), 1'b0, k == n - 1);
        end
      end
      CMD_FINISH: begin
        owe_result(KIND_FINAL, coder_state, count_sum != FULL_SUM, 1'b1);
        coder_state = LOWER_BOUND;
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Offer one request, optionally after a random gap, and hold it until taken.
  // Called right after a rising edge; valid stays high into the next request
  // when no gap is drawn, so it gets a single assignment per edge.
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [SYM_W-1:0] sym,
                              input logic [COUNT_W-1:0] cnt);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_symbol  <= sym;
    in_count   <= cnt;
    do @(posedge clk); while (in_ready !== 1'b1);
    encode_request(cmd, sym, cnt);
    if (cmd != CMD_UNUSED) requests_sent++;
  endtask

  // Drop valid and wait for every owed result to come back, then step to a
  // fresh edge so the next request drives valid only once.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Random stalls, plus a long hold-off whenever the test asks for one.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_requests != hold_served) begin
        hold_served = hold_requests;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (fail_count < PRINT_LIMIT)
      $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
    fail_count++;
  endtask

  // Match every accepted result against the oldest owed one.
  always @(posedge clk) begin
    enc_result_t want;
    if (rst_n && out_valid !== 1'b0 && out_ready) begin
      if (owed_results.size() == 0) begin
        report_mismatch("result with no request pending, data", 32'(out_data), '0);
      end else begin
        want = owed_results.pop_front();
        if (out_valid !== 1'b1)
          report_mismatch("valid", 32'(out_valid), 32'(1'b1));
        if (out_kind !== want.kind)
          report_mismatch("kind", 32'(out_kind), 32'(want.kind));
        if (out_data !== want.data)
          report_mismatch("data", 32'(out_data), 32'(want.data));
        if (out_table_bad !== want.table_bad)
          report_mismatch("table_bad", 32'(out_table_bad), 32'(want.table_bad));
        if (out_last !== want.last)
          report_mismatch("last", 32'(out_last), 32'(want.last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus building blocks
  // ---------------------------------------------------------------------------

  // Load k counts from symbol 'first' upward. An exact table sums to the full
  // precision; otherwise counts are drawn freely from zero to full precision.
  task automatic load_table(input int first, input int k, input bit exact);
    int left;
    int c;
    left = 1 << PRECISION_BITS;
    for (int s = first; s < first + k; s++) begin
      if (!exact)
        c = $urandom_range(0, 1 << PRECISION_BITS);
      else if (s == first + k - 1)
        c = left;
      else begin
        c = $urandom_range(0, (2 * left) / (first + k - s));
        if (c > left) c = left;
      end
      send_request(CMD_LOAD, s[SYM_W-1:0], c[COUNT_W-1:0]);
      left -= c;
    end
  endtask

  // Pick a loaded symbol below k, steering clear of zero counts most of the time.
  function automatic int pick_symbol(input int k);
    int s;
    s = $urandom_range(0, k - 1);
    if ($urandom_range(0, 19) != 0)
      for (int tries = 0; tries < 16 && sym_count[s] == 0; tries++)
        s = $urandom_range(0, k - 1);
    return s;
  endfunction

  // One random frame: mostly a clean table, a run of encodes and a finish;
  // sometimes a malformed table or plain noise.
  task automatic run_frame();
    int pick;
    int k;
    int m;
    int s;
    pick = $urandom_range(0, 99);
    m    = $urandom_range(4, 40);
    if (pick < 75) begin
      k = ($urandom_range(0, 19) == 0) ? $urandom_range(64, SYMBOL_COUNT)
                                       : $urandom_range(2, 12);
      load_table(0, k, 1'b1);
      repeat (m) begin
        s = pick_symbol(k);
        send_request(CMD_ENCODE, s[SYM_W-1:0], COUNT_W'($urandom_range(0, 8191)));
      end
      send_request(CMD_FINISH, SYM_W'($urandom_range(0, 255)),
                   COUNT_W'($urandom_range(0, 8191)));
    end else if (pick < 90) begin
      // Partial table, possibly not starting at symbol 0 so the sum carries on.
      k = $urandom_range(1, 8);
      load_table($urandom_range(0, SYMBOL_COUNT - k), k, 1'b0);
      repeat (m)
        send_request(CMD_ENCODE, SYM_W'($urandom_range(0, 255)), '0);
      // Leave the frame open now and then; the state carries into the next one.
      if ($urandom_range(0, 2) != 0) send_request(CMD_FINISH, '0, '0);
    end else begin
      repeat (6)
        send_request(CMD_W'($urandom_range(0, 3)), SYM_W'($urandom_range(0, 255)),
                     COUNT_W'($urandom_range(0, 1 << PRECISION_BITS)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes, every command, zero counts, the unused command, start overflow.
  task automatic test_directed();
    idle_pct  = 0;
    stall_pct = 0;
    send_request(CMD_FINISH, '0, '0);           // untouched state, empty table
    send_request(CMD_ENCODE, '0, '0);           // zero count -> error
    send_request(CMD_UNUSED, 8'hFF, 13'd4096);  // drop silently
    send_request(CMD_LOAD, '0, 13'd4096);       // single symbol owns everything
    send_request(CMD_ENCODE, '0, '0);
    send_request(CMD_FINISH, '0, '0);
    send_request(CMD_LOAD, '0, 13'd1);          // smallest nonzero count
    send_request(CMD_LOAD, 8'hFF, 13'd4095);    // top symbol
    send_request(CMD_ENCODE, '0, '0);           // one byte out
    send_request(CMD_ENCODE, '0, '0);           // two bytes out
    send_request(CMD_ENCODE, 8'hFF, 13'h1FFF);  // no bytes, count field ignored
    send_request(CMD_ENCODE, 8'h80, '0);        // never loaded -> error
    send_request(CMD_FINISH, 8'hFF, 13'h1FFF);
    send_request(CMD_LOAD, '0, '0);             // restart the sum with a zero count
    send_request(CMD_LOAD, 8'd1, 13'd4096);
    send_request(CMD_LOAD, 8'd2, 13'd4096);
    send_request(CMD_LOAD, 8'd3, 13'd4096);     // start no longer fits 13 bits
    send_request(CMD_ENCODE, 8'd3, '0);
    send_request(CMD_ENCODE, 8'd3, '0);
    send_request(CMD_ENCODE, 8'd1, '0);
    send_request(CMD_ENCODE, '0, '0);           // zero count leaves state alone
    send_request(CMD_FINISH, '0, '0);           // table sums too high
    drain_results();
  endtask

  // Push the cumulative sum past 21 bits so it wraps back to exactly full scale.
  task automatic test_sum_wrap();
    send_request(CMD_LOAD, '0, 13'd4096);
    for (int i = 0; i < 512; i++)
      send_request(CMD_LOAD, SYM_W'(1 + i % (SYMBOL_COUNT - 1)), 13'd4096);
    send_request(CMD_ENCODE, 8'd1, '0);
    send_request(CMD_ENCODE, 8'd200, '0);
    send_request(CMD_ENCODE, 8'd255, '0);
    send_request(CMD_FINISH, '0, '0);
    drain_results();
  endtask

  // Hold the result side off while requests keep coming, so the block backs up.
  task automatic test_backpressure();
    idle_pct  = 0;
    stall_pct = 0;
    send_request(CMD_LOAD, '0, 13'd16);
    send_request(CMD_LOAD, 8'd1, 13'd4080);
    hold_requests++;
    // Every encode of the small-count symbol spills one byte.
    repeat (24) send_request(CMD_ENCODE, '0, '0);
    send_request(CMD_FINISH, '0, '0);
    drain_results();
  endtask

  task automatic test_random_traffic(input int sender_idle, input int receiver_stall,
                                     input int budget);
    int target;
    idle_pct  = sender_idle;
    stall_pct = receiver_stall;
    target    = requests_sent + budget;
    while (requests_sent < target) run_frame();
    drain_results();
  endtask

  initial begin
    clear_encoder();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_sum_wrap();
    test_backpressure();
    test_random_traffic(0, 0, 250);
    test_random_traffic(57, 0, 250);
    test_random_traffic(0, 57, 250);
    test_random_traffic(11, 11, 250);

    // Catch any stray result after the last one owed.
    stall_pct = 0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && owed_results.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
